[hdl/plrt_pkg.sv]
// Shared types and constants of the per-label reduction table.
// Used by every module of the block; depends on nothing.
package plrt_pkg;

  // Capacity and value width of the accumulator store
  localparam int MAX_LABELS  = 1024;
  localparam int VALUE_WIDTH = 32;

  // Fixed field widths of the ports
  localparam int PIXEL_W    = 32;
  localparam int LABEL_W    = 16;
  localparam int OP_W       = 2;
  localparam int MODE_W     = 2;
  localparam int CNT_W      = 11;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  // Derived widths
  localparam int IDX_W   = (MAX_LABELS > 1) ? $clog2(MAX_LABELS) : 1;
  localparam int MAXC_W  = $clog2(MAX_LABELS + 1);
  localparam int LIM_W   = (CNT_W > MAXC_W) ? CNT_W : MAXC_W;
  localparam int CMP_W   = (LIM_W > LABEL_W) ? LIM_W : LABEL_W;

  // Epoch tags kept next to each entry; tag 0 is never a live epoch
  localparam int EPOCH_W = 8;
  localparam logic [EPOCH_W-1:0] EPOCH_FIRST = EPOCH_W'(1);
  localparam logic [EPOCH_W-1:0] EPOCH_LAST  = {EPOCH_W{1'b1}};
  localparam logic [IDX_W-1:0]   IDX_LAST    = IDX_W'(MAX_LABELS - 1);

  // Queue depths
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);
  localparam int RESQ_DEPTH = 4;
  localparam int RESQ_PTR_W = $clog2(RESQ_DEPTH);
  localparam int RESQ_CNT_W = $clog2(RESQ_DEPTH + 1);

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ACCUM = 2'd1,
    OP_READ  = 2'd2,
    OP_NOP   = 2'd3
  } op_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SUM = 2'd0,
    MODE_MAX = 2'd1,
    MODE_MIN = 2'd2,
    MODE_OR  = 2'd3
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_REDUCE_MODE = 1'b0,
    CFG_LABEL_COUNT = 1'b1
  } cfg_idx_t;

  // Classified item handed from front to back
  typedef struct packed {
    op_t                    op;
    logic                   in_range;
    logic [IDX_W-1:0]       idx;
    logic [VALUE_WIDTH-1:0] px;
  } cmd_t;

  // One result beat
  typedef struct packed {
    logic [PIXEL_W-1:0] read_value;
    logic               label_in_range;
  } res_t;

  // One word of the accumulator store
  typedef struct packed {
    logic [EPOCH_W-1:0]     tag;
    logic [VALUE_WIDTH-1:0] val;
  } entry_t;

endpackage

[hdl/per_label_reduction_table_unit.sv]
// Per-label reduction table: one accumulator per label folded by sum, max, min or OR.
// Sustained rate is one item per cycle unless the clearing pass or a full result queue stalls;
// an item passes the command queue, the store read, then fold and write, where its
// result beat is pushed. After reset, and after every 255th clear, an epoch-tag clearing
// pass walks the 1024-entry store one entry a cycle with in_full held high. Other clears
// bump the epoch tag, so entries of older epochs read as the current mode's start value.
// Depends on plrt_pkg, plrt_front, plrt_back and plrt_resq.
module per_label_reduction_table_unit (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic [plrt_pkg::OP_W-1:0]              in_op,
  input  logic signed [plrt_pkg::PIXEL_W-1:0]    in_pixel_value,
  input  logic signed [plrt_pkg::LABEL_W-1:0]    in_region_label,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic signed [plrt_pkg::PIXEL_W-1:0]    out_read_value,
  output logic                                   out_label_in_range,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [plrt_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [plrt_pkg::CFG_DATA_W-1:0]        cfg_wdata
);
  import plrt_pkg::*;

  mode_t                 mode_r;
  logic [CNT_W-1:0]      label_count_r;
  logic                  hold;
  logic                  cmd_valid;
  cmd_t                  cmd;
  logic                  cmd_pop;
  logic [RESQ_CNT_W-1:0] res_cnt;
  logic                  res_push;
  res_t                  res;
  res_t                  head;

  // configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r        <= MODE_SUM;
      label_count_r <= CNT_W'(1024);
    end else if (cfg_valid) begin
      case (cfg_idx_t'(cfg_index))
        CFG_REDUCE_MODE: mode_r        <= mode_t'(cfg_wdata[MODE_W-1:0]);
        CFG_LABEL_COUNT: label_count_r <= cfg_wdata[CNT_W-1:0];
        default:         mode_r        <= mode_r;
      endcase
    end
  end

  plrt_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_op           (in_op),
    .in_pixel_value  (in_pixel_value),
    .in_region_label (in_region_label),
    .label_count     (label_count_r),
    .hold            (hold),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_pop         (cmd_pop)
  );

  plrt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .mode      (mode_r),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .res_cnt   (res_cnt),
    .res_push  (res_push),
    .res       (res),
    .sweeping  (hold)
  );

  plrt_resq u_resq (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .head      (head),
    .cnt       (res_cnt)
  );

  assign out_read_value     = head.read_value;
  assign out_label_in_range = head.label_in_range;

endmodule

[hdl/plrt_front.sv]
// Front end: accepts input beats, checks the label range, queues classified items.
// Depends on plrt_pkg.
module plrt_front (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_push,
  output logic                                in_full,
  input  logic [plrt_pkg::OP_W-1:0]           in_op,
  input  logic signed [plrt_pkg::PIXEL_W-1:0] in_pixel_value,
  input  logic signed [plrt_pkg::LABEL_W-1:0] in_region_label,
  input  logic [plrt_pkg::CNT_W-1:0]          label_count,
  input  logic                                hold,
  output logic                                cmd_valid,
  output plrt_pkg::cmd_t                      cmd,
  input  logic                                cmd_pop
);
  import plrt_pkg::*;

  logic [LIM_W-1:0]      cnt_ext;
  logic [LIM_W-1:0]      limit;
  cmd_t                  cls;
  logic                  wr_en;
  cmd_t                  q_r [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [CMDQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CMDQ_CNT_W-1:0] cnt_r, cnt_nxt;

  // effective count is the smaller of the register and the capacity
  assign cnt_ext = LIM_W'(label_count);
  assign limit   = (cnt_ext < LIM_W'(MAX_LABELS)) ? cnt_ext : LIM_W'(MAX_LABELS);

  // classify the incoming beat
  always_comb begin
    cls.op       = op_t'(in_op);
    cls.in_range = !in_region_label[LABEL_W-1] &&
                   (CMP_W'($unsigned(in_region_label)) < CMP_W'(limit));
    cls.idx      = in_region_label[IDX_W-1:0];
    cls.px       = VALUE_WIDTH'(in_pixel_value);
  end

  assign in_full   = (cnt_r == CMDQ_CNT_W'(CMDQ_DEPTH)) || hold;
  assign wr_en     = in_push && !in_full;
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_ptr_r];

  // pointer and count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (wr_en) begin
      wr_ptr_nxt = (wr_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (cmd_pop) begin
      rd_ptr_nxt = (rd_ptr_r == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (wr_en && !cmd_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!wr_en && cmd_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (wr_en) begin
      q_r[wr_ptr_r] <= cls;
    end
  end

endmodule

[hdl/plrt_back.sv]
// Back end: accumulator store with epoch tags, read-fold-write pipe, clearing pass.
// Depends on plrt_pkg.
module plrt_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  plrt_pkg::mode_t                   mode,
  input  logic                              cmd_valid,
  input  plrt_pkg::cmd_t                    cmd,
  output logic                              cmd_pop,
  input  logic [plrt_pkg::RESQ_CNT_W-1:0]   res_cnt,
  output logic                              res_push,
  output plrt_pkg::res_t                    res,
  output logic                              sweeping
);
  import plrt_pkg::*;

  entry_t                 mem [MAX_LABELS];
  entry_t                 rd_q;
  logic                   b_valid_r;
  cmd_t                   b_cmd_r;
  logic                   fwd_v_r;
  logic [IDX_W-1:0]       fwd_idx_r;
  entry_t                 fwd_data_r;
  logic [EPOCH_W-1:0]     epoch_r, epoch_nxt;
  logic                   sweep_r, sweep_nxt;
  logic [IDX_W-1:0]       sweep_idx_r, sweep_idx_nxt;
  logic                   room;
  logic                   wrap_hold;
  logic                   issue;
  entry_t                 cur;
  logic [VALUE_WIDTH-1:0] acc;
  logic [VALUE_WIDTH-1:0] start;
  logic [VALUE_WIDTH-1:0] folded;
  logic                   acc_we;
  logic                   mem_we;
  logic [IDX_W-1:0]       mem_waddr;
  entry_t                 mem_wdata;
  logic                   b_clear;

  // issue only with room for this beat and the one in the second stage
  assign room = ((RESQ_CNT_W + 1)'(res_cnt) + (RESQ_CNT_W + 1)'(b_valid_r)) <
                (RESQ_CNT_W + 1)'(RESQ_DEPTH);
  assign b_clear   = b_valid_r && (b_cmd_r.op == OP_CLEAR);
  // a clear at the last epoch starts a pass; nothing may follow it into the pipe
  assign wrap_hold = b_clear && (epoch_r == EPOCH_LAST);
  assign issue     = cmd_valid && !sweep_r && !wrap_hold && room;
  assign cmd_pop   = issue;
  assign sweeping  = sweep_r;

  // second stage: forward the write that raced with this read
  assign cur = (fwd_v_r && (fwd_idx_r == b_cmd_r.idx)) ? fwd_data_r : rd_q;

  // start value of the current mode
  always_comb begin
    case (mode)
      MODE_MAX: start = {1'b1, {(VALUE_WIDTH - 1){1'b0}}};
      MODE_MIN: start = {1'b0, {(VALUE_WIDTH - 1){1'b1}}};
      default:  start = '0;
    endcase
  end

  assign acc = (cur.tag == epoch_r) ? cur.val : start;

  // fold the pixel into the entry
  always_comb begin
    case (mode)
      MODE_SUM: folded = b_cmd_r.px + acc;
      MODE_MAX: folded = ($signed(b_cmd_r.px) < $signed(acc)) ? acc : b_cmd_r.px;
      MODE_MIN: folded = ($signed(acc) < $signed(b_cmd_r.px)) ? acc : b_cmd_r.px;
      MODE_OR:  folded = ((b_cmd_r.px != '0) || (acc != '0)) ? VALUE_WIDTH'(1) : '0;
      default:  folded = acc;
    endcase
  end

  assign acc_we = b_valid_r && (b_cmd_r.op == OP_ACCUM) && b_cmd_r.in_range;

  // store write port: clearing pass or accumulate
  always_comb begin
    mem_we    = acc_we || sweep_r;
    mem_waddr = sweep_r ? sweep_idx_r : b_cmd_r.idx;
    mem_wdata = sweep_r ? entry_t'('0) : entry_t'({epoch_r, folded});
  end

  // result beat
  always_comb begin
    res_push           = b_valid_r;
    res.label_in_range = b_cmd_r.in_range;
    res.read_value     = ((b_cmd_r.op == OP_READ) && b_cmd_r.in_range) ?
                         PIXEL_W'($signed(acc)) : '0;
  end

  // epoch and clearing pass
  always_comb begin
    epoch_nxt     = epoch_r;
    sweep_nxt     = sweep_r;
    sweep_idx_nxt = sweep_idx_r;
    if (sweep_r) begin
      sweep_idx_nxt = sweep_idx_r + 1'b1;
      if (sweep_idx_r == IDX_LAST) begin
        sweep_nxt = 1'b0;
        epoch_nxt = EPOCH_FIRST;
      end
    end else if (b_clear) begin
      if (epoch_r == EPOCH_LAST) begin
        sweep_nxt     = 1'b1;
        sweep_idx_nxt = '0;
      end else begin
        epoch_nxt = epoch_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r   <= 1'b0;
      fwd_v_r     <= 1'b0;
      epoch_r     <= EPOCH_FIRST;
      sweep_r     <= 1'b1;
      sweep_idx_r <= '0;
    end else begin
      b_valid_r   <= issue;
      fwd_v_r     <= acc_we;
      epoch_r     <= epoch_nxt;
      sweep_r     <= sweep_nxt;
      sweep_idx_r <= sweep_idx_nxt;
    end
  end

  // stage payload and forward copy
  always_ff @(posedge clk) begin
    if (issue) begin
      b_cmd_r <= cmd;
    end
    fwd_idx_r  <= b_cmd_r.idx;
    fwd_data_r <= mem_wdata;
  end

  // accumulator store
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_q <= mem[cmd.idx];
    end
  end

endmodule

[hdl/plrt_resq.sv]
// Result queue: holds finished result beats until the consumer pops them.
// Depends on plrt_pkg.
module plrt_resq (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            res_push,
  input  plrt_pkg::res_t                  res,
  input  logic                            out_pop,
  output logic                            out_empty,
  output plrt_pkg::res_t                  head,
  output logic [plrt_pkg::RESQ_CNT_W-1:0] cnt
);
  import plrt_pkg::*;

  res_t                  q_r [RESQ_DEPTH];
  logic [RESQ_PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [RESQ_PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [RESQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  rd_en;

  assign out_empty = (cnt_r == '0);
  assign rd_en     = out_pop && !out_empty;
  assign head      = q_r[rd_ptr_r];
  assign cnt       = cnt_r;

  // pointers and fill count; the back end never pushes into a full queue
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (res_push) begin
      wr_ptr_nxt = (wr_ptr_r == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_nxt = (rd_ptr_r == RESQ_PTR_W'(RESQ_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (res_push && !rd_en) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!res_push && rd_en) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) begin
      q_r[wr_ptr_r] <= res;
    end
  end

endmodule

[hdl/plrt_checker.sv]
// Port-level checks for the per-label reduction table, bound to the top level.
// Depends on plrt_pkg and per_label_reduction_table_unit.
module plrt_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_full,
  input logic                                out_empty,
  input logic                                out_pop,
  input logic signed [plrt_pkg::PIXEL_W-1:0] out_read_value,
  input logic                                out_label_in_range
);
  import plrt_pkg::*;

  // reset leaves no result beat behind
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result queue not empty after reset");

  // the clearing pass after reset blocks input
  a_reset_full: assert property (@(posedge clk) !rst_n |=> in_full)
    else $error("input accepted during clearing pass");

  // an out-of-range label never carries a read value
  a_range_value: assert property (@(posedge clk) disable iff (!rst_n)
      !out_empty && !out_label_in_range |-> out_read_value == '0)
    else $error("read value on out-of-range label");

  // a waiting result beat holds until popped
  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
      !out_empty && !out_pop |=> !out_empty && $stable(out_read_value) &&
                                 $stable(out_label_in_range))
    else $error("result beat changed while waiting");

endmodule

bind per_label_reduction_table_unit plrt_checker u_plrt_checker (.*);
